/* hdl/tmq_pkg.sv */
// Package for the timed event queue: payload words, queue entry and codes.
// Used by tmq_store, tmq_cmp and timed_event_queue; depends on nothing.

package tmq_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_SCHEDULE = 2'd0;
   localparam logic [1:0] KIND_CANCEL   = 2'd1;
   localparam logic [1:0] KIND_QUERY    = 2'd2;
   localparam logic [1:0] KIND_NOTIFY   = 2'd3;

   // Operations of the shared compare unit.
   typedef enum logic [1:0] {
      CMP_LE = 2'b01,
      CMP_EQ = 2'b10
   } cmp_op_type;

   // Request word.
   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] time_value;
      logic [31:0] target_id;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [31:0] evt_id;
      logic [31:0] event_time;
      logic        found;
      logic        full_error;
      logic [4:0]  fired_count;
      logic [31:0] now_time;
      logic        last;
   } rsp_type;

   // One stored queue entry.
   typedef struct packed {
      logic [31:0] due_time;
      logic [31:0] evt_id;
   } entry_type;

   // Memory port strobes from the sequencer.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

/* hdl/tmq_store.sv */
// Entry memory of the timed event queue: one write port, one registered read port.
// Depends on tmq_pkg for the entry type.

module tmq_store #(
   parameter int DEPTH = 16
) (
   input  logic                      clock,
   input  tmq_pkg::mem_ctl_type      mem_ctl,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  tmq_pkg::entry_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output tmq_pkg::entry_type        rd_data
);

   tmq_pkg::entry_type mem_ff [DEPTH];
   tmq_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/tmq_cmp.sv */
// Shared compare unit of the timed event queue: unsigned less-or-equal or equality.
// Depends on tmq_pkg for the operation codes.

module tmq_cmp (
   input  tmq_pkg::cmp_op_type op,
   input  logic [31:0]         a,
   input  logic [31:0]         b,
   output logic                hit
);

   // One 32-bit comparator serves both the time and the id tests.
   always_comb begin
      case (op)
         tmq_pkg::CMP_LE: hit = (a <= b);
         tmq_pkg::CMP_EQ: hit = (a == b);
         default:         hit = 1'b0;
      endcase
   end

endmodule

/* hdl/timed_event_queue.sv */
// Timed event queue: sorted entry memory walked one entry at a time by a sequencer.
// A schedule moves each later entry up one slot from the tail and writes the new one in the gap;
// cancel and query walk the entries (a query stops at its hit); notify fires the due entries
// and moves the kept ones down; a full queue or a zero id is answered without walking the memory.
// One request at a time; the next is taken in the cycle after the final word is loaded.
// Sync active-high reset: queue empty, next id one, time zero. Uses tmq_pkg, tmq_store, tmq_cmp.

module timed_event_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tmq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tmq_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_READ  = 7'b0000010,
      S_EVAL  = 7'b0000100,
      S_FIRE  = 7'b0001000,
      S_CREAD = 7'b0010000,
      S_CMOVE = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [31:0]        next_id_ff, next_id_in;
   logic [31:0]        now_ff, now_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tmq_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic [1:0]         kind_ff, kind_in;
   logic [31:0]        tv_ff, tv_in;
   logic [31:0]        tid_ff, tid_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      wp_ff, wp_in;
   logic [CW-1:0]      fired_ff, fired_in;
   logic               found_ff, found_in;
   logic               full_ff, full_in;

   tmq_pkg::mem_ctl_type mem_ctl;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   tmq_pkg::entry_type   wr_data;
   tmq_pkg::entry_type   rd_data;
   tmq_pkg::entry_type   new_entry;

   tmq_pkg::cmp_op_type  cmp_op;
   logic [31:0]          cmp_a;
   logic [31:0]          cmp_b;
   logic                 cmp_hit;

   logic                 req_accept;
   logic                 slot_free;
   logic                 is_sched;
   logic                 is_notify;
   logic                 is_search;
   logic [CW-1:0]        idx_m1;
   logic [CW-1:0]        idx_p1;
   logic [31:0]          next_id_inc;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign is_sched  = (kind_ff == tmq_pkg::KIND_SCHEDULE);
   assign is_notify = (kind_ff == tmq_pkg::KIND_NOTIFY);
   assign is_search = kind_ff inside {tmq_pkg::KIND_CANCEL, tmq_pkg::KIND_QUERY};
   assign idx_m1    = idx_ff - CW'(1);
   assign idx_p1    = idx_ff + CW'(1);
   assign next_id_inc = next_id_ff + 32'd1;
   assign new_entry = '{due_time: tv_ff, evt_id: next_id_ff};

   // Shared compare: id match for cancel and query, due test otherwise.
   assign cmp_op = is_search ? tmq_pkg::CMP_EQ : tmq_pkg::CMP_LE;
   assign cmp_a  = is_search ? rd_data.evt_id : rd_data.due_time;
   assign cmp_b  = is_search ? tid_ff : tv_ff;

   tmq_cmp u_cmp (
      .op  (cmp_op),
      .a   (cmp_a),
      .b   (cmp_b),
      .hit (cmp_hit)
   );

   tmq_store #(
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: next state, memory strobes and response word.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      next_id_in   = next_id_ff;
      now_in       = now_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      tv_in        = tv_ff;
      tid_in       = tid_ff;
      idx_in       = idx_ff;
      wp_in        = wp_ff;
      fired_in     = fired_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      mem_ctl      = '{rd_en: 1'b0, wr_en: 1'b0};
      rd_addr      = idx_ff[AW-1:0];
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               kind_in  = req_data.kind;
               tv_in    = req_data.time_value;
               tid_in   = req_data.target_id;
               idx_in   = '0;
               wp_in    = '0;
               fired_in = '0;
               found_in = 1'b0;
               full_in  = 1'b0;
               state_in = S_READ;
               if (req_data.kind == tmq_pkg::KIND_SCHEDULE) begin
                  idx_in = count_ff;
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     full_in  = 1'b1;
                     state_in = S_RESP;
                  end
               end else if (req_data.kind != tmq_pkg::KIND_NOTIFY &&
                            req_data.target_id == 32'd0) begin
                  state_in = S_RESP;
               end
            end
         end

         S_READ: begin
            if (is_sched) begin
               // Walk down from the tail; at the head the new entry goes in slot zero.
               if (idx_ff == '0) begin
                  mem_ctl.wr_en = 1'b1;
                  wr_data       = new_entry;
                  state_in      = S_RESP;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  rd_addr       = idx_m1[AW-1:0];
                  state_in      = S_EVAL;
               end
            end else if (idx_ff == count_ff) begin
               state_in = is_notify ? S_CREAD : S_RESP;
            end else begin
               mem_ctl.rd_en = 1'b1;
               state_in      = S_EVAL;
            end
         end

         S_EVAL: begin
            if (is_sched) begin
               // A later entry moves up one slot; otherwise the new one lands here.
               mem_ctl.wr_en = 1'b1;
               if (!cmp_hit) begin
                  idx_in   = idx_m1;
                  state_in = S_READ;
               end else begin
                  wr_data  = new_entry;
                  state_in = S_RESP;
               end
            end else if (is_search) begin
               // After a cancel hit, every following entry moves down one slot.
               if (found_ff) begin
                  mem_ctl.wr_en = 1'b1;
                  wr_addr       = idx_m1[AW-1:0];
                  idx_in        = idx_p1;
                  state_in      = S_READ;
               end else if (cmp_hit) begin
                  found_in = 1'b1;
                  idx_in   = idx_p1;
                  state_in = (kind_ff == tmq_pkg::KIND_QUERY) ? S_RESP : S_READ;
               end else begin
                  idx_in   = idx_p1;
                  state_in = S_READ;
               end
            end else begin
               state_in = cmp_hit ? S_FIRE : S_CREAD;
            end
         end

         S_FIRE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{evt_id: rd_data.evt_id, event_time: rd_data.due_time,
                                found: 1'b0, full_error: 1'b0, fired_count: 5'd0,
                                now_time: rd_data.due_time, last: 1'b0};
               now_in       = rd_data.due_time;
               fired_in     = fired_ff + CW'(1);
               idx_in       = idx_p1;
               state_in     = S_READ;
            end
         end

         S_CREAD: begin
            // Close the gap left by the fired entries.
            if (idx_ff == count_ff) begin
               state_in = S_RESP;
            end else begin
               mem_ctl.rd_en = 1'b1;
               state_in      = S_CMOVE;
            end
         end

         S_CMOVE: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = wp_ff[AW-1:0];
            wp_in         = wp_ff + CW'(1);
            idx_in        = idx_p1;
            state_in      = S_CREAD;
         end

         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{evt_id: (is_sched && !full_ff) ? next_id_ff : 32'd0,
                                event_time: 32'd0, found: found_ff, full_error: full_ff,
                                fired_count: is_notify ? 5'(fired_ff) : 5'd0,
                                now_time: is_notify ? tv_ff : now_ff, last: 1'b1};
               if (is_sched && !full_ff) begin
                  count_in   = count_ff + CW'(1);
                  next_id_in = (next_id_inc == 32'd0) ? 32'd1 : next_id_inc;
               end
               if (kind_ff == tmq_pkg::KIND_CANCEL && found_ff) begin
                  count_in = count_ff - CW'(1);
               end
               if (is_notify) begin
                  count_in = count_ff - fired_ff;
                  now_in   = tv_ff;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_id_ff   <= 32'd1;
         now_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Work registers and response word.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      kind_ff     <= kind_in;
      tv_ff       <= tv_in;
      tid_ff      <= tid_in;
      idx_ff      <= idx_in;
      wp_ff       <= wp_in;
      fired_ff    <= fired_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
   end

   // The entry count never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   // The memory is left alone while the block waits for a request.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !mem_ctl.wr_en && !mem_ctl.rd_en)
      else $error("memory access while idle");

   // A fired word reports its own due time as the current time.
   a_fire_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.last |-> rsp_data_ff.now_time == rsp_data_ff.event_time)
      else $error("fired word time mismatch");

   // A refused schedule leaves the entry count alone.
   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP && full_ff |=> count_ff == $past(count_ff))
      else $error("entry count changed on full queue");

endmodule
